// ===== rtl/tcw_pkg.sv =====
// tcw_pkg: shared constants, control-word types and the microcode rom of the
// text console writer; no dependencies, imported by every other file
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // fixed field widths
  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_ATTR = '0;
  localparam logic [ATTR_W-1:0]  ATTR_RESET    = 8'h07;

  // character and colour constants
  localparam logic [ATTR_W-1:0] PANIC_ATTR   = 8'h4f;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;

  // item modes
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PANIC = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

  // microprogram steps
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_WR_CHAR, S_WR_CHK, S_SC_RD, S_SC_WR, S_SC_BLANK, S_SC_END,
    S_CLR, S_CLR_END, S_PN_RD, S_PN_WR, S_RD, S_RD_CAP, S_DONE
  } step_t;

  typedef enum logic [2:0] {
    COND_ALWAYS, COND_ACCEPT, COND_LAST_CELL, COND_LAST_COPY, COND_ROW_OK, COND_OUT_FREE
  } cond_t;

  typedef enum logic [1:0] {ADDR_HOLD, ADDR_ZERO, ADDR_INC} addr_op_t;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_RD_ADDR, MEM_RD_SRC, MEM_RD_INDEX, MEM_WR, MEM_WR_CURSOR
  } mem_op_t;

  typedef enum logic [2:0] {WD_ZERO, WD_BLANK, WD_CHAR, WD_COPY, WD_PANIC} wsel_t;

  typedef enum logic [1:0] {CUR_HOLD, CUR_ADVANCE, CUR_HOME, CUR_LAST_ROW} cur_op_t;

  typedef struct packed {
    cond_t    cond;
    step_t    tgt_true;
    step_t    tgt_false;
    logic     dispatch;
    addr_op_t addr_op;
    mem_op_t  mem_op;
    wsel_t    wsel;
    cur_op_t  cur_op;
    logic     in_ready;
    logic     set_scroll;
    logic     capture;
    logic     load_out;
  } ctrl_t;

  localparam ctrl_t CTRL_NOP = '{
    cond: COND_ALWAYS, tgt_true: S_IDLE, tgt_false: S_IDLE, dispatch: 1'b0,
    addr_op: ADDR_HOLD, mem_op: MEM_NONE, wsel: WD_ZERO, cur_op: CUR_HOLD,
    in_ready: 1'b0, set_scroll: 1'b0, capture: 1'b0, load_out: 1'b0
  };

  // control store: one word per step
  function automatic ctrl_t tcw_rom(step_t s);
    ctrl_t w;
    w = CTRL_NOP;
    unique case (s)
      S_INIT: begin
        w.cond = COND_LAST_CELL; w.tgt_true = S_IDLE; w.tgt_false = S_INIT;
        w.addr_op = ADDR_INC; w.mem_op = MEM_WR; w.wsel = WD_ZERO;
      end
      S_IDLE: begin
        w.cond = COND_ACCEPT; w.dispatch = 1'b1; w.tgt_false = S_IDLE;
        w.addr_op = ADDR_ZERO; w.in_ready = 1'b1;
      end
      S_WR_CHAR: begin
        w.tgt_true = S_WR_CHK; w.mem_op = MEM_WR_CURSOR; w.wsel = WD_CHAR;
        w.cur_op = CUR_ADVANCE;
      end
      S_WR_CHK: begin
        w.cond = COND_ROW_OK; w.tgt_true = S_DONE; w.tgt_false = S_SC_RD;
      end
      S_SC_RD: begin
        w.tgt_true = S_SC_WR; w.mem_op = MEM_RD_SRC;
      end
      S_SC_WR: begin
        w.cond = COND_LAST_COPY; w.tgt_true = S_SC_BLANK; w.tgt_false = S_SC_RD;
        w.addr_op = ADDR_INC; w.mem_op = MEM_WR; w.wsel = WD_COPY;
      end
      S_SC_BLANK: begin
        w.cond = COND_LAST_CELL; w.tgt_true = S_SC_END; w.tgt_false = S_SC_BLANK;
        w.addr_op = ADDR_INC; w.mem_op = MEM_WR; w.wsel = WD_BLANK;
      end
      S_SC_END: begin
        w.tgt_true = S_DONE; w.cur_op = CUR_LAST_ROW; w.set_scroll = 1'b1;
      end
      S_CLR: begin
        w.cond = COND_LAST_CELL; w.tgt_true = S_CLR_END; w.tgt_false = S_CLR;
        w.addr_op = ADDR_INC; w.mem_op = MEM_WR; w.wsel = WD_BLANK;
      end
      S_CLR_END: begin
        w.tgt_true = S_DONE; w.cur_op = CUR_HOME;
      end
      S_PN_RD: begin
        w.tgt_true = S_PN_WR; w.mem_op = MEM_RD_ADDR;
      end
      S_PN_WR: begin
        w.cond = COND_LAST_CELL; w.tgt_true = S_DONE; w.tgt_false = S_PN_RD;
        w.addr_op = ADDR_INC; w.mem_op = MEM_WR; w.wsel = WD_PANIC;
      end
      S_RD: begin
        w.tgt_true = S_RD_CAP; w.mem_op = MEM_RD_INDEX;
      end
      S_RD_CAP: begin
        w.tgt_true = S_DONE; w.capture = 1'b1;
      end
      S_DONE: begin
        w.cond = COND_OUT_FREE; w.tgt_true = S_IDLE; w.tgt_false = S_DONE;
        w.load_out = 1'b1;
      end
      default: w = CTRL_NOP;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tcw_in_if.sv =====
// tcw_in_if: input item channel of the text console writer
// depends on tcw_pkg for field widths
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, mode, char_code, cell_index, input ready);
  modport sink   (input valid, mode, char_code, cell_index, output ready);
  modport monitor (input valid, ready, mode, char_code, cell_index);
endinterface

`default_nettype wire

// ===== rtl/tcw_out_if.sv =====
// tcw_out_if: result channel of the text console writer
// depends on tcw_pkg for field widths
`default_nettype none

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_data;
  logic              scrolled;

  modport source (output valid, cursor_position, cell_data, scrolled, input ready);
  modport sink   (input valid, cursor_position, cell_data, scrolled, output ready);
  modport monitor (input valid, ready, cursor_position, cell_data, scrolled);
endinterface

`default_nettype wire

// ===== rtl/text_console_writer_core.sv =====
// text_console_writer_core: microcoded console engine over a cell memory
// depends on tcw_pkg, tcw_in_if and tcw_out_if
//
//   channel   dir   handshake        payload
//   item      in    valid/ready      mode, char_code, cell_index
//   result    out   valid/ready      cursor_position, cell_data, scrolled
//   apb       in    psel/penable     text_attribute at byte address 0
//
// character write: steps WR_CHAR, WR_CHK and DONE; cell read: RD, RD_CAP and DONE,
// set by the step sequence of the control store. clear writes every cell once;
// panic reads and rewrites every cell; a scroll copies the rows up and blanks the
// bottom row, as each control word issues one memory operation and so one cell moves per read/write pair.
// after reset a clearing pass zeroes every cell with item ready low. a stalled
// result holds the block in its final step.
`default_nettype none

module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  tcw_in_if.sink                  item,
  tcw_out_if.source               result
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int LIN_W      = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam logic [AW-1:0] CELL_LAST = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] COPY_LAST = AW'((ROWS - 1) * COLUMNS - 1);

  step_t pc, pc_next;
  ctrl_t ctrl;
  logic  cond_true;
  logic  accept;
  logic  out_free;

  logic [ATTR_W-1:0] text_attribute;
  logic [AW-1:0]     addr;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [CHAR_W-1:0] char_q;
  logic [IDX_W-1:0]  idx_q;
  logic              scroll_flag;
  logic [CELL_W-1:0] read_data;
  logic [LIN_W-1:0]  cur_lin;

  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rdata;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  logic              printable;
  logic              idx_in_range;
  logic [COL_W-1:0]  col_adv, col_plus;
  logic [ROW_W-1:0]  row_adv;

  // apb register
  assign pready = 1'b1;
  assign prdata = PDATA_W'(text_attribute);

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_TEXT_ATTR) begin
      text_attribute <= pwdata[ATTR_W-1:0];
    end
  end

  // sequencer
  assign accept   = item.valid && item.ready;
  assign out_free = !result.valid || result.ready;
  assign item.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_INIT;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    ctrl = tcw_rom(pc);
    unique case (ctrl.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_ACCEPT:    cond_true = accept;
      COND_LAST_CELL: cond_true = (addr == CELL_LAST);
      COND_LAST_COPY: cond_true = (addr == COPY_LAST);
      COND_ROW_OK:    cond_true = (32'(cur_row) < 32'(ROWS));
      COND_OUT_FREE:  cond_true = out_free;
      default:        cond_true = 1'b0;
    endcase
    pc_next = cond_true ? ctrl.tgt_true : ctrl.tgt_false;
    if (ctrl.dispatch && cond_true) begin
      unique case (item.mode)
        MODE_WRITE: pc_next = S_WR_CHAR;
        MODE_CLEAR: pc_next = S_CLR;
        MODE_PANIC: pc_next = S_PN_RD;
        MODE_READ:  pc_next = S_RD;
        default:    pc_next = S_IDLE;
      endcase
    end
  end

  // cursor arithmetic
  assign cur_lin      = LIN_W'(cur_row) * LIN_W'(COLUMNS) + LIN_W'(cur_col);
  assign printable    = (char_q[CHAR_W-1:5] != '0) && !char_q[CHAR_W-1];
  assign idx_in_range = (32'(idx_q) < 32'(CELL_COUNT));
  assign col_plus     = cur_col + COL_W'(1);

  always_comb begin
    col_adv = printable ? col_plus : cur_col;
    row_adv = cur_row;
    if (char_q == NEWLINE_CHAR || 32'(col_adv) >= 32'(COLUMNS)) begin
      col_adv = '0;
      row_adv = cur_row + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
    end else begin
      case (ctrl.cur_op)
        CUR_ADVANCE: begin
          cur_col <= col_adv;
          cur_row <= row_adv;
        end
        CUR_HOME: begin
          cur_col <= '0;
          cur_row <= '0;
        end
        CUR_LAST_ROW: cur_row <= ROW_W'(ROWS - 1);
        default: ;
      endcase
    end
  end

  // address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      case (ctrl.addr_op)
        ADDR_ZERO: addr <= '0;
        ADDR_INC:  addr <= addr + AW'(1);
        default: ;
      endcase
    end
  end

  // item capture and per-item flags
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_flag <= 1'b0;
    end else if (accept) begin
      scroll_flag <= 1'b0;
    end else if (ctrl.set_scroll) begin
      scroll_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_q    <= item.char_code;
      idx_q     <= item.cell_index;
      read_data <= '0;
    end else if (ctrl.capture) begin
      read_data <= idx_in_range ? rdata : '0;
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr;
    mem_raddr = addr;
    unique case (ctrl.mem_op)
      MEM_NONE: ;
      MEM_RD_ADDR: mem_re = 1'b1;
      MEM_RD_SRC: begin
        mem_re    = 1'b1;
        mem_raddr = addr + AW'(COLUMNS);
      end
      MEM_RD_INDEX: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(idx_q);
      end
      MEM_WR: mem_we = 1'b1;
      MEM_WR_CURSOR: begin
        // control bytes and high bytes leave the cell alone
        mem_we    = printable;
        mem_waddr = AW'(cur_lin);
      end
      default: ;
    endcase
    unique case (ctrl.wsel)
      WD_ZERO:  mem_wdata = '0;
      WD_BLANK: mem_wdata = {text_attribute, BLANK_CHAR};
      WD_CHAR:  mem_wdata = {text_attribute, char_q};
      WD_COPY:  mem_wdata = rdata;
      WD_PANIC: mem_wdata = {PANIC_ATTR, rdata[CHAR_W-1:0]};
      default:  mem_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctrl.load_out && cond_true) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out && cond_true) begin
      result.cursor_position <= POS_W'(cur_lin);
      result.cell_data       <= read_data;
      result.scrolled        <= scroll_flag;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
// tcw_checker: port-level assertions for text_console_writer_core, with bind
// depends on tcw_pkg, tcw_in_if and tcw_out_if
`default_nettype none

module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input wire logic  clk,
  input wire logic  rst,
  tcw_in_if.sink    item,
  tcw_out_if.source result
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam logic [POS_W-1:0] LAST_ROW_START = POS_W'((ROWS - 1) * COLUMNS);

  // one item in flight: ready drops right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> !item.ready)
    else $error("item ready high in the cycle after a transaction");

  // a scroll always leaves the cursor at the start of the bottom row
  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.scrolled |-> result.cursor_position == LAST_ROW_START)
    else $error("scrolled result with cursor off the bottom row start");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (CELL_COUNT > (1 << POS_W)) ||
                     (32'(result.cursor_position) < 32'(CELL_COUNT)))
    else $error("cursor position beyond the screen");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid &&
      $stable(result.cursor_position) && $stable(result.cell_data) &&
      $stable(result.scrolled))
    else $error("stalled result changed");

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tcw_checker (
  .clk   (clk),
  .rst   (rst),
  .item  (item),
  .result(result)
);

`default_nettype wire

// ===== bench/tcw_console_checker.sv =====
`timescale 1ns / 100ps
// tcw_console_checker: watches the item, result and apb channels of the text console
// writer, tracks the screen contents and compares every result with the prediction
// depends on tcw_pkg, tcw_in_if and tcw_out_if
module tcw_console_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  tcw_in_if.monitor               item,
  tcw_out_if.monitor              result,
  output int                      mismatches,
  output int                      pending
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } console_view_t;

  logic [CELL_W-1:0] screen [CELLS];
  int                cur_col;
  int                cur_row;
  logic [ATTR_W-1:0] text_attr;
  console_view_t     expected_views [$];
  console_view_t     seen;
  console_view_t     want;

  // applies one item to the tracked screen and returns what the block should report
  function automatic console_view_t advance_console(logic [MODE_W-1:0] mode,
                                                     logic [CHAR_W-1:0] ch,
                                                     logic [IDX_W-1:0] idx);
    console_view_t v;
    v = '0;
    case (mode)
      MODE_WRITE: begin
        // high bytes count as negative chars and are skipped like control bytes
        if (ch >= BLANK_CHAR && !ch[CHAR_W-1]) begin
          screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
          cur_col++;
        end
        if (ch == NEWLINE_CHAR || cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {text_attr, BLANK_CHAR};
          cur_row = ROWS - 1;
          v.scrolled = 1'b1;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {text_attr, BLANK_CHAR};
        cur_col = 0;
        cur_row = 0;
      end
      MODE_PANIC: begin
        for (int i = 0; i < CELLS; i++) screen[i][CELL_W-1:CHAR_W] = PANIC_ATTR;
      end
      MODE_READ: begin
        if (idx < CELLS) v.cell_data = screen[idx];
      end
      default: ;
    endcase
    v.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = '0;
      cur_col = 0;
      cur_row = 0;
      text_attr = ATTR_RESET;
      expected_views.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ATTR_ADDR)
        text_attr = pwdata[ATTR_W-1:0];
      if (item.valid && item.ready)
        expected_views.push_back(advance_console(item.mode, item.char_code, item.cell_index));
      if (result.valid && result.ready) begin
        seen = '{pos: result.cursor_position, cell_data: result.cell_data,
                 scrolled: result.scrolled};
        if (expected_views.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected result transaction: pos %0d cell %h sc %0b",
                     $time, seen.pos, seen.cell_data, seen.scrolled);
        end else begin
          want = expected_views.pop_front();
          if (seen != want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: mismatch: want pos %0d cell %h sc %0b, got pos %0d cell %h sc %0b",
                       $time, want.pos, want.cell_data, want.scrolled,
                       seen.pos, seen.cell_data, seen.scrolled);
          end
        end
      end
      pending <= expected_views.size();
    end
  end

endmodule

// ===== bench/tb_text_console_writer_core.sv =====
`timescale 1ns / 100ps
// tb_text_console_writer_core: drives items, result back-pressure and attribute writes
// into the console writer and gives the verdict from the checker's counts
// depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_console_checker and the core
module tb_text_console_writer_core import tcw_pkg::*; ();

  localparam int IDLE_LIMIT  = 20000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 340;
  localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  wire  [PDATA_W-1:0] prdata;
  wire                pready;

  logic sink_ready = 1'b0;
  int   sink_hold = 0;
  int   sink_draw;
  int   results_seen = 0;
  bit   sink_calm = 1'b0;
  bit   source_calm = 1'b0;
  int   source_count = 0;
  int   idle_cycles = 0;
  int   mismatches;
  int   pending;

  tcw_in_if  item_ch ();
  tcw_out_if result_ch ();

  assign result_ch.ready = sink_ready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_writer_core #(.COLUMNS(DEF_COLUMNS), .ROWS(DEF_ROWS)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .item(item_ch), .result(result_ch)
  );

  tcw_console_checker #(.COLUMNS(DEF_COLUMNS), .ROWS(DEF_ROWS)) u_checker (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata),
    .item(item_ch), .result(result_ch),
    .mismatches(mismatches), .pending(pending)
  );

  // result side: random stall after each transaction, with calm stretches
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      sink_hold <= 0;
    end else if (result_ch.valid && sink_ready) begin
      results_seen <= results_seen + 1;
      if ((results_seen % 32) == 0) sink_calm <= ($urandom_range(0, 3) == 0);
      sink_draw = sink_calm ? 0 : $urandom_range(0, 6);
      sink_hold <= sink_draw;
      sink_ready <= (sink_draw == 0);
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      sink_ready <= (sink_hold == 1);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // clears, panics and scrolls touch every cell of the screen, so the limit is generous
  always @(posedge clk) begin
    if (rst || psel || (item_ch.valid && item_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                           input logic [IDX_W-1:0] idx);
    int gap;
    if ((source_count % 32) == 0) source_calm = ($urandom_range(0, 3) == 0);
    source_count++;
    gap = source_calm ? 0 : $urandom_range(0, 6);
    // valid stays high across back-to-back transactions
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.mode <= mode;
    item_ch.char_code <= ch;
    item_ch.cell_index <= idx;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  task automatic drain_items();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ATTR_ADDR;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_item(input int newline_pct);
    int pick;
    int kind;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    pick = $urandom_range(0, 999);
    ch = CHAR_W'($urandom_range(0, 255));
    idx = IDX_W'($urandom_range(0, 2047));
    if (pick < 5) begin
      send_item(MODE_CLEAR, ch, idx);
    end else if (pick < 15) begin
      send_item(MODE_PANIC, ch, idx);
    end else if (pick < 175) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) idx = IDX_W'($urandom_range(2000, 2047));
      else if (kind < 5) idx = IDX_W'($urandom_range(0, 399));
      else idx = IDX_W'($urandom_range(0, 1999));
      send_item(MODE_READ, ch, idx);
    end else begin
      kind = $urandom_range(0, 99);
      if (kind < newline_pct) ch = NEWLINE_CHAR;
      else if (kind < newline_pct + 8) ch = CHAR_W'($urandom_range(8'h80, 8'hff));
      else if (kind < newline_pct + 14) ch = CHAR_W'($urandom_range(8'h00, 8'h1f));
      else ch = CHAR_W'($urandom_range(8'h20, 8'h7f));
      send_item(MODE_WRITE, ch, idx);
    end
  endtask

  initial begin : stimulus
    logic [ATTR_W-1:0] attr_pick;
    int newline_pct;
    item_ch.valid <= 1'b0;
    item_ch.mode <= MODE_WRITE;
    item_ch.char_code <= '0;
    item_ch.cell_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: printable extremes, skipped bytes, newline, reads at the edges, a panic and a clear
    send_item(MODE_WRITE, 8'h48, 11'd0);
    send_item(MODE_WRITE, BLANK_CHAR, 11'd0);
    send_item(MODE_WRITE, 8'h7f, 11'd2047);
    send_item(MODE_WRITE, 8'h80, 11'd0);
    send_item(MODE_WRITE, 8'hff, 11'd0);
    send_item(MODE_WRITE, 8'h00, 11'd0);
    send_item(MODE_WRITE, 8'h1f, 11'd0);
    send_item(MODE_WRITE, NEWLINE_CHAR, 11'd0);
    send_item(MODE_WRITE, 8'h7e, 11'd0);
    send_item(MODE_READ, 8'hff, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1);
    send_item(MODE_READ, 8'h00, 11'd2);
    send_item(MODE_READ, 8'h00, 11'd3);
    send_item(MODE_READ, 8'h00, 11'd80);
    send_item(MODE_READ, 8'h00, 11'd1999);
    send_item(MODE_READ, 8'h00, 11'd2000);
    send_item(MODE_READ, 8'h00, 11'd2047);
    send_item(MODE_PANIC, 8'hff, 11'd2047);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd81);
    send_item(MODE_CLEAR, 8'h41, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd0);
    send_item(MODE_READ, 8'h00, 11'd1999);
    drain_items();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: attr_pick = 8'hff;
        1: attr_pick = 8'h00;
        default: attr_pick = ATTR_W'($urandom_range(0, 255));
      endcase
      write_attribute(attr_pick);
      newline_pct = $urandom_range(5, 25);
      repeat (PHASE_ITEMS) random_item(newline_pct);
      drain_items();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
